### design/rled_pkg.sv
package rled_pkg;

  // default width of the row position counter
  localparam int ROW_COUNT_BITS_DEF = 16;

  // result queue depth, a power of two of at least 2
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  // configuration register indexes
  localparam logic CFG_TWO_BYTE    = 1'b0;
  localparam logic CFG_ROW_SAMPLES = 1'b1;

  // decode phases
  localparam logic [1:0] PH_CONTROL = 2'd0;
  localparam logic [1:0] PH_VALUE   = 2'd1;
  localparam logic [1:0] PH_LITERAL = 2'd2;

  localparam logic [6:0]  RUN_COUNT_MASK = 7'h7f;
  localparam int          LITERAL_BIT    = 7;
  localparam logic [15:0] PAD_BYTE       = 16'h00ff;
  localparam logic [15:0] PAD_WORD       = 16'hffff;

  typedef struct packed {
    logic [15:0] sample_in;
    logic        has_sample;
    logic        row_end;
    logic        fill_opaque;
  } in_item_t;

  typedef struct packed {
    logic [15:0] run_value;
    logic [15:0] run_count;
    logic        last_of_row;
  } out_item_t;

  // front to queue: number of new results and the results themselves
  typedef struct packed {
    logic [1:0] n;
    out_item_t  e0;
    out_item_t  e1;
  } push_t;

endpackage

### design/rled_front.sv
module rled_front import rled_pkg::*; #(
  parameter int ROW_COUNT_BITS = ROW_COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  in_item_t    item,
  input  logic        two_byte_samples,
  input  logic [15:0] row_samples,
  output push_t       push
);

  logic [1:0]                phase, phase_next;
  logic [6:0]                pending, pending_next;
  logic [ROW_COUNT_BITS-1:0] produced, produced_next;
  logic                      stopped, stopped_next;

  logic [ROW_COUNT_BITS+15:0] lim_wide;
  logic [ROW_COUNT_BITS-1:0]  lim, room, room_after, c, pend_ext;
  logic [ROW_COUNT_BITS+15:0] c_wide, pad_wide;
  logic [15:0]                s;
  logic                       data_push;
  out_item_t                  data_run, pad_run;

  assign lim_wide = {{ROW_COUNT_BITS{1'b0}}, row_samples};
  assign lim      = lim_wide[ROW_COUNT_BITS-1:0];
  assign room     = (produced < lim) ? (lim - produced) : '0;
  assign s        = two_byte_samples ? item.sample_in : {8'h00, item.sample_in[7:0]};
  assign pend_ext = {{(ROW_COUNT_BITS-7){1'b0}}, pending};
  assign c        = (pend_ext < room) ? pend_ext : room;
  assign c_wide   = {16'h0000, c};

  always_comb begin
    phase_next    = phase;
    pending_next  = pending;
    produced_next = produced;
    stopped_next  = stopped;
    room_after    = room;
    data_push     = 1'b0;
    data_run      = '{run_value: s, run_count: 16'd1, last_of_row: 1'b0};

    if (!item.has_sample) begin
      stopped_next = 1'b1;
    end else if (!stopped) begin
      unique case (phase)
        PH_VALUE: begin
          data_push          = 1'b1;
          data_run.run_count = c_wide[15:0];
          produced_next      = produced + c;
          room_after         = room - c;
          pending_next       = '0;
          phase_next         = PH_CONTROL;
          if (pend_ext >= room) begin
            stopped_next = 1'b1;
          end
        end
        PH_LITERAL: begin
          if (room != '0) begin
            data_push     = 1'b1;
            produced_next = produced + 1'b1;
            room_after    = room - 1'b1;
          end
          pending_next = pending - 7'd1;
          if (pending == 7'd1) begin
            phase_next = PH_CONTROL;
          end
          if (room <= {{(ROW_COUNT_BITS-1){1'b0}}, 1'b1}) begin
            stopped_next = 1'b1;
          end
        end
        default: begin
          if (room == '0 || (s[6:0] & RUN_COUNT_MASK) == 7'd0) begin
            stopped_next = 1'b1;
          end else begin
            pending_next = s[6:0] & RUN_COUNT_MASK;
            phase_next   = s[LITERAL_BIT] ? PH_LITERAL : PH_VALUE;
          end
        end
      endcase
    end

    pad_wide = {16'h0000, room_after};
    pad_run.run_value   = item.fill_opaque ? (two_byte_samples ? PAD_WORD : PAD_BYTE) : 16'h0000;
    pad_run.run_count   = pad_wide[15:0];
    pad_run.last_of_row = 1'b1;

    if (item.row_end) begin
      phase_next    = PH_CONTROL;
      pending_next  = '0;
      produced_next = '0;
      stopped_next  = 1'b0;
    end

    push.e0 = data_push ? data_run : pad_run;
    push.e1 = pad_run;
    push.n  = 2'd0;
    if (accept) begin
      push.n = {1'b0, data_push} + {1'b0, item.row_end};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_CONTROL;
      pending  <= '0;
      produced <= '0;
      stopped  <= 1'b0;
    end else if (accept) begin
      phase    <= phase_next;
      pending  <= pending_next;
      produced <= produced_next;
      stopped  <= stopped_next;
    end
  end

endmodule

### design/rled_queue.sv
module rled_queue import rled_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  push_t     push,
  output logic      full,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  out_item_t             mem [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]  wr_ptr, rd_ptr;
  logic [QCNT_BITS-1:0]  count;
  logic                  pop;

  assign out_valid = (count != '0);
  assign out_data  = mem[rd_ptr];
  assign pop       = out_valid && !out_stall;
  // room for two results is needed before an item can enter
  assign full      = (count > QCNT_BITS'(QUEUE_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem[wr_ptr] <= push.e0;
    end
    if (push.n == 2'd2) begin
      mem[wr_ptr + 1'b1] <= push.e1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_BITS'(push.n);
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + QCNT_BITS'(push.n) - QCNT_BITS'(pop);
    end
  end

endmodule

### design/sgi_rle_scanline_decoder.sv
// A request's runs enter the queue at the edge that accepts it; in an empty queue
// the first is valid in the cycle after. One request per cycle while in_stall is
// low; runs leave the four-entry queue one per cycle while out_stall is low.
// in_stall rises while fewer than two queue entries are free.
// Reset (rst, synchronous): row state cleared, queue emptied, byte mode,
// row_samples = 1.
module sgi_rle_scanline_decoder import rled_pkg::*; #(
  parameter int ROW_COUNT_BITS = ROW_COUNT_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  // configuration registers, used directly by the front end
  logic        two_byte_samples;
  logic [15:0] row_samples;

  logic  accept;
  logic  full;
  push_t push;

  always_ff @(posedge clk) begin
    if (rst) begin
      two_byte_samples <= 1'b0;
      row_samples      <= 16'd1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_TWO_BYTE:    two_byte_samples <= cfg_data[0];
        CFG_ROW_SAMPLES: row_samples      <= cfg_data;
        default:         ;
      endcase
    end
  end

  // front end takes a request whenever the queue can absorb both of its
  // possible results (data run plus pad run)
  assign in_stall = full;
  assign accept   = in_valid && !in_stall;

  // front: classifies control / repeat value / literal samples, tracks the
  // row position and emits up to two runs per request
  rled_front #(
    .ROW_COUNT_BITS(ROW_COUNT_BITS)
  ) u_front (
    .clk              (clk),
    .rst              (rst),
    .accept           (accept),
    .item             (in_data),
    .two_byte_samples (two_byte_samples),
    .row_samples      (row_samples),
    .push             (push)
  );

  // back: run queue draining toward the output handshake
  rled_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### design/rled_checker.sv
module rled_checker import rled_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  a_rst_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("queue not empty after reset");

  a_row_end_out: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && in_data.row_end |=> out_valid)
    else $error("row end request produced no result");

  // an empty run queue always has room for a request
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled while no result is queued");

endmodule

bind sgi_rle_scanline_decoder rled_checker u_rled_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

### tb/sgi_rle_scanline_decoder_tb.sv
`timescale 1ns / 1ps

module sgi_rle_scanline_decoder_tb;
  import rled_pkg::*;

  // quiet cycles (no request or run accepted) before the run is declared hung
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_REQUESTS = 1100;
  // requests at the tail of the random part that run with no idling at all
  localparam int CALM_TAIL = 150;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_write = 1'b0;
  logic        cfg_index = CFG_TWO_BYTE;
  logic [15:0] cfg_data = '0;

  // decoder model state, mirrors the block's reset values
  logic        word_mode = 1'b0;
  logic [15:0] row_len = 16'd1;
  logic [1:0]  dec_phase = PH_CONTROL;
  logic [6:0]  run_left = '0;
  logic [15:0] row_fill = '0;
  logic        row_stopped = 1'b0;

  out_item_t   runs_due[$];   // runs predicted but not yet seen at the output
  out_item_t   want;
  int          mismatches = 0;
  int          items_sent = 0;
  logic        idle_on = 1'b1;
  int          stall_left = 0;

  sgi_rle_scanline_decoder uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ------------------------------------------------------------------
  // Run predictor
  // ------------------------------------------------------------------

  // samples still free in the current row
  function automatic logic [15:0] room_left();
    return (row_fill < row_len) ? row_len - row_fill : 16'd0;
  endfunction

  function automatic void push_run(input logic [15:0] value, input logic [15:0] count,
                                   input logic closes);
    out_item_t r;
    r.run_value   = value;
    r.run_count   = count;
    r.last_of_row = closes;
    runs_due.push_back(r);
  endfunction

  // Advance the decoder by one accepted request and queue the runs it yields:
  // at most one data run, then the pad run when the request closes the row.
  function automatic void decode_item(input in_item_t it);
    logic [15:0] s;
    logic [15:0] room;
    logic [15:0] c;
    s = it.sample_in;
    if (!word_mode) s[15:8] = 8'h00;   // byte mode: upper byte is don't-care
    if (!it.has_sample) begin
      row_stopped = 1'b1;
    end else if (!row_stopped) begin
      room = room_left();
      case (dec_phase)
        PH_VALUE: begin
          // repeat run, clipped to what is left of the row
          c = ({9'd0, run_left} < room) ? {9'd0, run_left} : room;
          push_run(s, c, 1'b0);
          row_fill  = row_fill + c;
          run_left  = '0;
          dec_phase = PH_CONTROL;
          if (room_left() == 16'd0) row_stopped = 1'b1;
        end
        PH_LITERAL: begin
          // literal sample beyond the row end is dropped
          if (room != 16'd0) begin
            push_run(s, 16'd1, 1'b0);
            row_fill = row_fill + 16'd1;
          end
          run_left = run_left - 7'd1;
          if (run_left == 7'd0) dec_phase = PH_CONTROL;
          if (room_left() == 16'd0) row_stopped = 1'b1;
        end
        default: begin
          // control sample: zero count or full row ends decoding
          if (room == 16'd0 || (s[6:0] & RUN_COUNT_MASK) == 7'd0) begin
            row_stopped = 1'b1;
          end else begin
            run_left  = s[6:0] & RUN_COUNT_MASK;
            dec_phase = s[LITERAL_BIT] ? PH_LITERAL : PH_VALUE;
          end
        end
      endcase
    end
    if (it.row_end) begin
      push_run(it.fill_opaque ? (word_mode ? PAD_WORD : PAD_BYTE) : 16'd0, room_left(), 1'b1);
      dec_phase   = PH_CONTROL;
      run_left    = '0;
      row_fill    = '0;
      row_stopped = 1'b0;
    end
  endfunction

  // ------------------------------------------------------------------
  // Drivers
  // ------------------------------------------------------------------

  function automatic in_item_t mk(input logic [15:0] smp, input logic has,
                                  input logic closes, input logic opq);
    in_item_t it;
    it.sample_in   = smp;
    it.has_sample  = has;
    it.row_end     = closes;
    it.fill_opaque = opq;
    return it;
  endfunction

  // Send one request; returns on the edge where it is accepted. Valid is left
  // high so back-to-back requests never drop it within one time step.
  task automatic send_item(input in_item_t it);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    // inputs only move at rising edges, so stall seen at the falling edge
    // is what the next rising edge will use
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    decode_item(it);
    items_sent++;
  endtask

  // Stop sending, let every predicted run drain, then wait for any request
  // still in flight that yields no run.
  task automatic settle();
    in_valid <= 1'b0;
    while (runs_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == CFG_TWO_BYTE) word_mode = val[0];
    else row_len = val;
    @(posedge clk);
  endtask

  // Receiver: random stall bursts while idling is on.
  always @(posedge clk) begin
    if (rst || !idle_on) begin
      stall_left <= 0;
      out_stall  <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if ($urandom_range(0, 9) == 0) stall_left <= $urandom_range(1, 15);
    end
  end

  // ------------------------------------------------------------------
  // Run checker: a run seen valid and unstalled at the falling edge is
  // taken at the next rising edge.
  // ------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (runs_due.size() == 0) begin
        $display("%0t: unexpected run value %h count %0d last %b", $time,
                 out_data.run_value, out_data.run_count, out_data.last_of_row);
        mismatches++;
      end else begin
        want = runs_due.pop_front();
        if (out_data.run_value !== want.run_value) begin
          $display("%0t: run_value expected %h actual %h", $time,
                   want.run_value, out_data.run_value);
          mismatches++;
        end
        if (out_data.run_count !== want.run_count) begin
          $display("%0t: run_count expected %0d actual %0d", $time,
                   want.run_count, out_data.run_count);
          mismatches++;
        end
        if (out_data.last_of_row !== want.last_of_row) begin
          $display("%0t: last_of_row expected %b actual %b", $time,
                   want.last_of_row, out_data.last_of_row);
          mismatches++;
        end
      end
    end
  end

  // Hang detector: ends the run after too long with no request or run moving.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(negedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no traffic for %0d cycles, %0d runs outstanding", $time,
             WATCHDOG_LIMIT, runs_due.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ------------------------------------------------------------------
  // Directed tests
  // ------------------------------------------------------------------

  // repeat run, literal run, byte mode ignoring the upper byte
  task automatic test_repeat_and_literal();
    settle();
    write_reg(CFG_TWO_BYTE, 16'd0);
    write_reg(CFG_ROW_SAMPLES, 16'd20);
    send_item(mk(16'hA503, 1'b1, 1'b0, 1'b0));   // repeat 3, junk upper byte
    send_item(mk(16'h5AC5, 1'b1, 1'b0, 1'b1));
    send_item(mk(16'h0082, 1'b1, 1'b0, 1'b0));   // literal 2
    send_item(mk(16'h0011, 1'b1, 1'b0, 1'b0));
    send_item(mk(16'hFF22, 1'b1, 1'b0, 1'b0));
    send_item(mk(16'h0000, 1'b0, 1'b1, 1'b1));   // empty marker closes the row, opaque pad
  endtask

  // clipping, full row, zero count, literal overrunning the row
  task automatic test_stop_conditions();
    settle();
    write_reg(CFG_ROW_SAMPLES, 16'd4);
    send_item(mk(16'h007F, 1'b1, 1'b0, 1'b0));   // repeat 127 into a row of 4
    send_item(mk(16'h0000, 1'b1, 1'b0, 1'b0));
    send_item(mk(16'h0083, 1'b1, 1'b1, 1'b0));   // ignored, pad of zero length
    send_item(mk(16'h0080, 1'b1, 1'b0, 1'b0));   // literal bit with count zero
    send_item(mk(16'h0012, 1'b1, 1'b1, 1'b1));
    settle();
    write_reg(CFG_ROW_SAMPLES, 16'd2);
    send_item(mk(16'h0083, 1'b1, 1'b0, 1'b0));   // literal 3 into a row of 2
    send_item(mk(16'h0001, 1'b1, 1'b0, 1'b0));
    send_item(mk(16'h0002, 1'b1, 1'b0, 1'b0));
    send_item(mk(16'h0003, 1'b1, 1'b1, 1'b0));
  endtask

  // missing sample, row ending mid-run and before the repeat value
  task automatic test_row_end_cases();
    settle();
    write_reg(CFG_ROW_SAMPLES, 16'd10);
    send_item(mk(16'h0083, 1'b1, 1'b0, 1'b0));
    send_item(mk(16'h0021, 1'b1, 1'b0, 1'b0));
    send_item(mk(16'h00EE, 1'b0, 1'b0, 1'b0));   // no sample: rest of the row is pad
    send_item(mk(16'h0044, 1'b1, 1'b1, 1'b1));
    send_item(mk(16'h0005, 1'b1, 1'b1, 1'b0));   // repeat value never arrives
    send_item(mk(16'h0003, 1'b1, 1'b0, 1'b0));
    send_item(mk(16'h0099, 1'b1, 1'b1, 1'b1));   // data run and pad together
  endtask

  // 16-bit samples at the field extremes, longest row
  task automatic test_word_samples();
    settle();
    write_reg(CFG_TWO_BYTE, 16'd1);
    write_reg(CFG_ROW_SAMPLES, 16'hFFFF);
    send_item(mk(16'h7F7F, 1'b1, 1'b0, 1'b0));   // repeat 127
    send_item(mk(16'hFFFF, 1'b1, 1'b0, 1'b0));
    send_item(mk(16'hFF81, 1'b1, 1'b0, 1'b0));   // literal 1
    send_item(mk(16'h8000, 1'b1, 1'b0, 1'b0));
    send_item(mk(16'h0000, 1'b1, 1'b1, 1'b1));   // zero count, opaque word pad
    send_item(mk(16'h1234, 1'b0, 1'b1, 1'b0));   // empty row
  endtask

  // zero row length and register writes while a row is open
  task automatic test_config_midrow();
    settle();
    write_reg(CFG_TWO_BYTE, 16'd0);
    write_reg(CFG_ROW_SAMPLES, 16'd0);
    send_item(mk(16'h0003, 1'b1, 1'b1, 1'b1));
    settle();
    write_reg(CFG_ROW_SAMPLES, 16'd10);
    send_item(mk(16'h0008, 1'b1, 1'b0, 1'b0));
    send_item(mk(16'h0077, 1'b1, 1'b0, 1'b0));
    settle();
    write_reg(CFG_ROW_SAMPLES, 16'd5);          // shrink below what is already out
    write_reg(CFG_TWO_BYTE, 16'hFFFF);          // only bit 0 matters
    send_item(mk(16'h1234, 1'b1, 1'b1, 1'b1));
  endtask

  // ------------------------------------------------------------------
  // Random rows
  // ------------------------------------------------------------------

  task automatic random_config();
    logic [15:0] len;
    case ($urandom_range(0, 9))
      0: len = 16'd0;
      1: len = 16'hFFFF;
      2: len = 16'($urandom_range(1, 65535));
      default: len = 16'($urandom_range(1, 48));
    endcase
    if ($urandom_range(0, 3) != 0) write_reg(CFG_TWO_BYTE, 16'($urandom));
    write_reg(CFG_ROW_SAMPLES, len);
  endtask

  // One scanline of mostly well-formed runs with random content, now and then
  // broken: zero counts, missing samples, rows cut short.
  task automatic send_random_row();
    in_item_t    row_q[$];
    logic [15:0] ctl;
    int          n_runs;
    int          cnt;
    int          cut;
    n_runs = $urandom_range(0, 5);
    for (int r = 0; r < n_runs; r++) begin
      ctl = 16'($urandom);
      ctl[LITERAL_BIT] = 1'($urandom_range(0, 1));
      cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 127) : $urandom_range(1, 6);
      if ($urandom_range(0, 19) == 0) cnt = 0;
      ctl[6:0] = 7'(cnt);
      row_q.push_back(mk(ctl, 1'b1, 1'b0, 1'($urandom)));
      if (ctl[LITERAL_BIT]) begin
        for (int k = 0; k < cnt; k++) row_q.push_back(mk(16'($urandom), 1'b1, 1'b0, 1'($urandom)));
      end else if (cnt != 0) begin
        row_q.push_back(mk(16'($urandom), 1'b1, 1'b0, 1'($urandom)));
      end
      if ($urandom_range(0, 24) == 0) row_q.push_back(mk(16'($urandom), 1'b0, 1'b0, 1'($urandom)));
    end
    if (row_q.size() != 0 && $urandom_range(0, 4) == 0) begin
      cut = $urandom_range(0, row_q.size() - 1);
      while (row_q.size() > cut) void'(row_q.pop_back());
    end
    // close on the last sample or on a separate marker
    if (row_q.size() == 0 || $urandom_range(0, 3) == 0)
      row_q.push_back(mk(16'($urandom), 1'($urandom_range(0, 1)), 1'b0, 1'($urandom)));
    row_q[row_q.size() - 1].row_end = 1'b1;
    foreach (row_q[i]) begin
      if (i != 0 && $urandom_range(0, 29) == 0) begin
        settle();
        random_config();
      end
      send_item(row_q[i]);
    end
  endtask

  task automatic test_random_rows();
    int stop_at;
    stop_at = items_sent + RANDOM_REQUESTS;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 5) == 0) begin
        settle();
        random_config();
      end
      // idling in random stretches, none at all near the end
      idle_on = (stop_at - items_sent > CALM_TAIL) && ($urandom_range(0, 4) != 0);
      send_random_row();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_repeat_and_literal();
    test_stop_conditions();
    test_row_end_cases();
    test_word_samples();
    test_config_midrow();
    test_random_rows();
    settle();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
